// ----- rtl/tlpt_pkg.sv -----
// Package: shared constants and types for the two-level page table manager.
`timescale 1ns / 1ps
`default_nettype none
package tlpt_pkg;
  localparam int unsigned TableSlotsDef = 16;
  localparam int unsigned TableEntries = 1024;
  localparam int unsigned IdxW = 10;
  localparam int unsigned DirShift = 22;
  localparam int unsigned PageShift = 12;
  localparam logic [31:0] LimitReset = 32'hC000_0000;

  localparam logic [1:0] REQ_MAP = 2'd0;
  localparam logic [1:0] REQ_UNMAP = 2'd1;
  localparam logic [1:0] REQ_XLATE = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_REFUSED = 2'd1;
  localparam logic [1:0] ST_NO_SLOT = 2'd2;
  localparam logic [1:0] ST_UNMAPPED = 2'd3;

  // page entry: present, writable, user, 20-bit frame
  typedef struct packed {
    logic [19:0] frame;
    logic        user;
    logic        writable;
    logic        present;
  } pte_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] phys_out;
    logic        entry_writable;
    logic        entry_user;
    logic        dir_user;
    logic        table_freed;
  } result_t;
endpackage
`default_nettype wire

// ----- rtl/two_level_page_table_manager.sv -----
// Top level: page directory and page tables held in synchronous memories.
// Map, unmap and translate pass through S_RD1, S_RD2 and S_DONE to the result; a
// refused map, a map with no free slot and an unknown request type skip S_RD2.
// A map that allocates a table adds a clearing sweep of all 1024 entries of that table.
// One request in flight; the next request is taken in the cycle the result leaves
// at the earliest, so a new request is never taken while one is in progress.
// Reset (rst_n low, synchronous): slot pool and live counts cleared by the reset, and
// the directory cleared by a sweep of all 1024 entries; no request taken meanwhile.
`timescale 1ns / 1ps
`default_nettype none
module two_level_page_table_manager
  import tlpt_pkg::*;
#(
  parameter int unsigned TABLE_SLOTS = TableSlotsDef
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_we,
  input  wire  [31:0] cfg_wdata,
  input  wire         in_tvalid,
  output logic        in_tready,
  // tdata: virt_addr[31:0], phys_addr[63:32], want_writable[64], want_user[65], zero fill
  input  wire  [71:0] in_tdata,
  // tuser: req_type[1:0]
  input  wire  [1:0]  in_tuser,
  output logic        out_tvalid,
  input  wire         out_tready,
  // tdata: phys_out[31:0], entry_writable[32], entry_user[33], dir_user[34],
  // table_freed[35], zero fill
  output logic [39:0] out_tdata,
  // tuser: status[1:0]
  output logic [1:0]  out_tuser
);
  localparam int unsigned SlotW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int unsigned EntW = SlotW + IdxW;
  localparam int unsigned CntW = $clog2(TableEntries) + 1;

  typedef struct packed {
    logic [SlotW-1:0] slot;
    logic             user;
    logic             present;
  } pde_t;

  typedef enum logic [2:0] {S_CLR, S_IDLE, S_RD1, S_RD2, S_TCLR, S_DONE} state_t;

  state_t state_r;
  logic [31:0] limit_r;
  logic [1:0]  req_r;
  logic [31:0] va_r, pa_r;
  logic        wr_r, us_r;
  logic [IdxW-1:0] sweep_r;
  logic [SlotW-1:0] newslot_r;
  pde_t pde_r;
  result_t res_r;
  logic    res_v_r;
  logic [TABLE_SLOTS-1:0] busy_r;
  logic [CntW-1:0] cnt_r [TABLE_SLOTS];

  pde_t dir_mem [TableEntries];
  pte_t ent_mem [TABLE_SLOTS*TableEntries];
  pde_t dir_q;
  pte_t ent_q;

  // directory memory port
  logic            dir_we;
  logic [IdxW-1:0] dir_wa, dir_ra;
  pde_t            dir_wd;
  // table memory port
  logic            ent_we;
  logic [EntW-1:0] ent_wa, ent_ra;
  pte_t            ent_wd;

  always_ff @(posedge clk) begin
    if (dir_we) dir_mem[dir_wa] <= dir_wd;
    dir_q <= dir_mem[dir_ra];
    if (ent_we) ent_mem[ent_wa] <= ent_wd;
    ent_q <= ent_mem[ent_ra];
  end

  wire [IdxW-1:0] d_idx = va_r[DirShift +: IdxW];
  wire [IdxW-1:0] t_idx = va_r[PageShift +: IdxW];

  // lowest free slot
  logic             free_any;
  logic [SlotW-1:0] free_slot;
  always_comb begin
    free_any = 1'b0;
    free_slot = '0;
    for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
      if (!busy_r[i]) begin
        free_any = 1'b1;
        free_slot = SlotW'(i);
      end
    end
  end

  // a freshly allocated table lives in newslot_r
  wire [SlotW-1:0] cur_slot = pde_r.present ? pde_r.slot : newslot_r;
  wire [CntW-1:0]  cur_cnt = cnt_r[cur_slot];
  pte_t new_pte;
  assign new_pte = '{frame: pa_r[31:PageShift], user: us_r, writable: wr_r, present: 1'b1};

  always_comb begin
    dir_we = 1'b0; dir_wa = d_idx; dir_wd = '0;
    ent_we = 1'b0; ent_wa = {newslot_r, sweep_r}; ent_wd = '0;
    dir_ra = in_tdata[DirShift +: IdxW];
    ent_ra = {dir_q.slot, t_idx};
    unique case (state_r)
      S_CLR: begin
        dir_we = 1'b1; dir_wa = sweep_r;
      end
      S_TCLR: begin
        ent_we = 1'b1;
      end
      S_RD2: begin
        if (req_r == REQ_MAP) begin
          ent_we = 1'b1; ent_wa = {cur_slot, t_idx}; ent_wd = new_pte;
          if (!pde_r.present) begin
            dir_we = 1'b1;
            dir_wd = '{slot: cur_slot, user: us_r, present: 1'b1};
          end
        end else if (req_r == REQ_UNMAP && pde_r.present && ent_q.present) begin
          ent_we = 1'b1; ent_wa = {cur_slot, t_idx};
          if (cur_cnt <= CntW'(1)) dir_we = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign in_tready = (state_r == S_IDLE) && (!res_v_r || out_tready);
  assign out_tvalid = res_v_r;
  assign out_tuser = res_r.status;
  assign out_tdata = {4'd0, res_r.table_freed, res_r.dir_user, res_r.entry_user,
                      res_r.entry_writable, res_r.phys_out};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      sweep_r <= '0;
      busy_r <= '0;
      res_v_r <= 1'b0;
      limit_r <= LimitReset;
      for (int i = 0; i < TABLE_SLOTS; i++) cnt_r[i] <= '0;
    end else begin
      if (cfg_we) limit_r <= cfg_wdata;
      if (res_v_r && out_tready) res_v_r <= 1'b0;
      unique case (state_r)
        S_CLR: begin
          sweep_r <= sweep_r + 1'b1;
          if (sweep_r == IdxW'(TableEntries - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_tvalid && in_tready) begin
            req_r <= in_tuser;
            va_r <= in_tdata[31:0];
            pa_r <= in_tdata[63:32];
            wr_r <= in_tdata[64];
            us_r <= in_tdata[65];
            res_r <= '0;
            state_r <= S_RD1;
          end
        end
        S_RD1: begin
          // directory entry is on dir_q; table read issued this cycle
          pde_r <= dir_q;
          state_r <= S_RD2;
          if (req_r == REQ_MAP) begin
            if (va_r[31:PageShift] >= limit_r[31:PageShift] && us_r &&
                ({va_r[31:PageShift], 12'd0} >= limit_r)) begin
              res_r.status <= ST_REFUSED;
              state_r <= S_DONE;
            end else if (!dir_q.present) begin
              if (!free_any) begin
                res_r.status <= ST_NO_SLOT;
                state_r <= S_DONE;
              end else begin
                newslot_r <= free_slot;
                busy_r[free_slot] <= 1'b1;
                cnt_r[free_slot] <= '0;
                sweep_r <= '0;
                state_r <= S_TCLR;
              end
            end
          end else if (req_r != REQ_UNMAP && req_r != REQ_XLATE) begin
            state_r <= S_DONE;
          end
        end
        S_TCLR: begin
          sweep_r <= sweep_r + 1'b1;
          if (sweep_r == IdxW'(TableEntries - 1)) state_r <= S_RD2;
        end
        S_RD2: begin
          state_r <= S_DONE;
          if (req_r == REQ_MAP) begin
            // fresh table reads as empty regardless of ent_q
            if ((!pde_r.present || !ent_q.present) && cur_cnt < CntW'(TableEntries))
              cnt_r[cur_slot] <= cur_cnt + 1'b1;
          end else if (req_r == REQ_UNMAP) begin
            if (!pde_r.present || !ent_q.present) begin
              res_r.status <= ST_UNMAPPED;
            end else begin
              if (cur_cnt != '0) cnt_r[cur_slot] <= cur_cnt - 1'b1;
              if (cur_cnt <= CntW'(1)) begin
                busy_r[cur_slot] <= 1'b0;
                res_r.table_freed <= 1'b1;
              end
            end
          end else begin
            if (!pde_r.present || !ent_q.present) begin
              res_r.status <= ST_UNMAPPED;
            end else begin
              res_r.phys_out <= {ent_q.frame, va_r[PageShift-1:0]};
              res_r.entry_writable <= ent_q.writable;
              res_r.entry_user <= ent_q.user;
              res_r.dir_user <= pde_r.user;
            end
          end
        end
        S_DONE: begin
          res_v_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
